// ===== rtl/nfct1_pkg.sv =====
// ----------------------------------------------------------------------------
// nfct1_pkg
// Shared types and constants for the Type 1 tag lock area tracker.
// ----------------------------------------------------------------------------
package nfct1_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_FEED  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [10:0] address;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		logic       locked;
		logic       parse_done;
		logic [3:0] area_count;
		logic       table_full;
	} rsp_t;

	localparam logic [15:0] STATIC_BYTES     = 16'd120;
	localparam logic [15:0] STATIC_LOCK_BASE = 16'(8'h0e * 8);

	localparam logic [7:0] TLV_NULL    = 8'h00;
	localparam logic [7:0] TLV_LOCK    = 8'h01;
	localparam logic [7:0] TLV_RESMEM  = 8'h02;
	localparam logic [7:0] TLV_NDEF    = 8'h03;
	localparam logic [7:0] TLV_PROP    = 8'hFD;
	localparam logic [7:0] TLV_TERM    = 8'hFE;
	localparam logic [7:0] LEN_ESCAPE  = 8'hff;

	// Parser phases.
	localparam logic [2:0] PH_TYPE   = 3'd0;
	localparam logic [2:0] PH_LEN    = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_VAL0   = 3'd4;
	localparam logic [2:0] PH_VAL1   = 3'd5;
	localparam logic [2:0] PH_VAL2   = 3'd6;
	localparam logic [2:0] PH_SKIP   = 3'd7;

endpackage

// ===== rtl/nfct1_front.sv =====
// ----------------------------------------------------------------------------
// nfct1_front
// Accepts requests into a two-entry queue that decouples the link side from
// the execution side.
// ----------------------------------------------------------------------------
module nfct1_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  nfct1_pkg::req_t request,
	output logic            req_valid,
	output nfct1_pkg::req_t req,
	input  logic            req_take
);
	import nfct1_pkg::*;

	req_t       slot_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] cnt_q;

	logic do_push, do_pop;

	assign full      = cnt_q[1];
	assign req_valid = (cnt_q != 2'd0);
	assign req       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = req_take && req_valid;

	// Queue storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= request;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/nfct1_back.sv =====
// ----------------------------------------------------------------------------
// nfct1_back
// Executes one request at a time: memory writes, TLV parsing, area table
// updates and lock queries, and holds the result in an output register.
// ----------------------------------------------------------------------------
module nfct1_back #(
	parameter int MEM_BYTES = 2048,
	parameter int MAX_AREAS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  nfct1_pkg::req_t req,
	output logic            req_take,
	output logic            empty,
	input  logic            pop,
	output nfct1_pkg::rsp_t result
);
	import nfct1_pkg::*;

	localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
	localparam int MW = $clog2(MEM_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_QUERY = 4'b0100,
		ST_RSV   = 4'b1000
	} state_t;

	state_t state_q;

	logic [7:0] mem_q [MEM_BYTES];
	logic [7:0] rd_data_q;

	logic [15:0] first_q  [MAX_AREAS];
	logic [15:0] offset_q [MAX_AREAS];
	logic [3:0]  shift_q  [MAX_AREAS];
	logic [4:0]  used_q;
	logic [15:0] next_q;
	logic [2:0]  phase_q;
	logic [7:0]  kind_q;
	logic [15:0] left_q;
	logic [7:0]  val_q [3];
	logic        stop_q;
	logic        drop_q;

	req_t        cur_q;
	logic        hit_q;
	logic [2:0]  bit_q;
	logic        have_q;
	rsp_t        rsp_q;

	// Area start and size from the held value bytes.
	logic [15:0] start_w, size_w, nl_adj;
	logic [8:0]  size9;
	always_comb begin
		start_w = 16'((32'(val_q[0][7:4]) << val_q[2][3:0]) + 32'(val_q[0][3:0]));
		size9   = (val_q[1] == 8'd0) ? 9'd256 : {1'b0, val_q[1]};
		size_w  = 16'(size9);
		nl_adj  = (start_w <= next_q) ? 16'(next_q + 16'((size9 + 9'd7) >> 3)) : next_q;
	end

	// Lock address computation for a query.
	logic [10:0] q_addr;
	logic        q_static;
	logic        q_found;
	logic [AW-1:0] q_idx;
	logic [15:0] q_bitno;
	logic [16:0] q_lock;
	always_comb begin
		q_addr   = cur_q.address;
		q_static = (16'(q_addr) < STATIC_BYTES);
		q_found  = 1'b0;
		q_idx    = '0;
		for (int i = 0; i < MAX_AREAS; i++) begin
			if (5'(i) < used_q && first_q[i] <= 16'(q_addr)) begin
				q_found = 1'b1;
				q_idx   = AW'(i);
			end
		end
		if (q_static) begin
			q_bitno = 16'(q_addr[10:3]);
			q_lock  = 17'(STATIC_LOCK_BASE) + 17'(q_bitno[15:3]);
		end else begin
			q_bitno = 16'((16'(q_addr) - first_q[q_idx]) >> shift_q[q_idx]);
			q_lock  = 17'(offset_q[q_idx]) + 17'(q_bitno[15:3]);
		end
	end

	logic q_ok;
	assign q_ok = (q_static || (q_found && offset_q[q_idx] >= STATIC_BYTES))
		&& (q_lock < 17'(MEM_BYTES));

	// A new request may start in the cycle the held result is popped.
	assign req_take = (state_q == ST_IDLE) && req_valid && (!have_q || pop);
	assign empty    = !have_q;
	assign result   = rsp_q;

	// Tag memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && cur_q.command == CMD_WRITE
			&& 32'(cur_q.address) < MEM_BYTES) begin
			mem_q[cur_q.address[MW-1:0]] <= cur_q.data;
		end
		rd_data_q <= mem_q[q_lock[MW-1:0]];
		if (state_q == ST_EXEC) begin
			hit_q <= q_ok;
			bit_q <= q_bitno[2:0];
		end
	end

	// Sequencer, parser and area table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_q  <= 1'b0;
			rsp_q   <= '0;
			cur_q   <= '0;
			used_q  <= '0;
			next_q  <= STATIC_BYTES;
			phase_q <= PH_TYPE;
			kind_q  <= '0;
			left_q  <= '0;
			stop_q  <= 1'b0;
			drop_q  <= 1'b0;
			for (int i = 0; i < 3; i++) val_q[i] <= '0;
			for (int i = 0; i < MAX_AREAS; i++) begin
				first_q[i]  <= '0;
				offset_q[i] <= '0;
				shift_q[i]  <= '0;
			end
		end else begin
			if (have_q && pop) have_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						cur_q   <= req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					rsp_q.locked <= 1'b0;
					case (cur_q.command)
						CMD_QUERY: state_q <= ST_QUERY;
						CMD_CLEAR: begin
							used_q  <= '0;
							next_q  <= STATIC_BYTES;
							phase_q <= PH_TYPE;
							kind_q  <= '0;
							left_q  <= '0;
							stop_q  <= 1'b0;
							drop_q  <= 1'b0;
							for (int i = 0; i < 3; i++) val_q[i] <= '0;
							for (int i = 0; i < MAX_AREAS; i++) begin
								first_q[i]  <= '0;
								offset_q[i] <= '0;
								shift_q[i]  <= '0;
							end
						end
						CMD_FEED: begin
							if (!stop_q) begin
								case (phase_q)
									PH_TYPE: begin
										if (cur_q.data == TLV_NDEF || cur_q.data == TLV_PROP
											|| cur_q.data == TLV_TERM) begin
											stop_q <= 1'b1;
										end else if (cur_q.data == TLV_LOCK
											|| cur_q.data == TLV_RESMEM) begin
											kind_q  <= cur_q.data;
											for (int i = 0; i < 3; i++) val_q[i] <= '0;
											phase_q <= PH_LEN;
										end
									end
									PH_LEN: begin
										if (cur_q.data == LEN_ESCAPE) begin
											phase_q <= PH_LEN_HI;
										end else begin
											left_q <= 16'(cur_q.data);
											if (cur_q.data == 8'd0) state_q <= ST_RSV;
											else phase_q <= PH_VAL0;
										end
									end
									PH_LEN_HI: begin
										left_q  <= {cur_q.data, 8'd0};
										phase_q <= PH_LEN_LO;
									end
									PH_LEN_LO: begin
										left_q <= {left_q[15:8], cur_q.data};
										if ({left_q[15:8], cur_q.data} == 16'd0) state_q <= ST_RSV;
										else phase_q <= PH_VAL0;
									end
									default: begin
										if (phase_q != PH_SKIP)
											val_q[2'(phase_q - PH_VAL0)] <= cur_q.data;
										left_q <= left_q - 16'd1;
										if (left_q == 16'd1) state_q <= ST_RSV;
										else if (phase_q != PH_SKIP) phase_q <= phase_q + 3'd1;
									end
								endcase
							end
						end
						default: ;
					endcase
					if (cur_q.command != CMD_QUERY) have_q <= 1'b1;
					rsp_q.parse_done <= (cur_q.command == CMD_CLEAR) ? 1'b0 :
						(stop_q || (cur_q.command == CMD_FEED && phase_q == PH_TYPE
						&& (cur_q.data == TLV_NDEF || cur_q.data == TLV_PROP
						|| cur_q.data == TLV_TERM)));
					rsp_q.area_count <= (cur_q.command == CMD_CLEAR) ? 4'd0 : 4'(used_q);
					rsp_q.table_full <= (cur_q.command == CMD_CLEAR) ? 1'b0 : drop_q;
					// A finishing TLV defers the result to the apply step.
					if (cur_q.command == CMD_FEED && !stop_q && (
						(phase_q == PH_LEN && cur_q.data == 8'd0 ) ||
						(phase_q == PH_LEN_LO && {left_q[15:8], cur_q.data} == 16'd0) ||
						(phase_q >= PH_VAL0 && left_q == 16'd1))) begin
						have_q <= 1'b0;
					end
				end
				ST_QUERY: begin
					rsp_q.locked     <= hit_q & rd_data_q[bit_q];
					rsp_q.parse_done <= stop_q;
					rsp_q.area_count <= 4'(used_q);
					rsp_q.table_full <= drop_q;
					have_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RSV: begin
					// Apply the finished TLV; reserved memory moves every matching area.
					phase_q <= PH_TYPE;
					state_q <= ST_IDLE;
					have_q  <= 1'b1;
					rsp_q.parse_done <= stop_q;
					rsp_q.table_full <= drop_q;
					rsp_q.area_count <= 4'(used_q);
					if (kind_q == TLV_LOCK) begin
						if (used_q >= 5'(MAX_AREAS)) begin
							drop_q <= 1'b1;
							rsp_q.table_full <= 1'b1;
						end else begin
							first_q[used_q[AW-1:0]]  <= nl_adj;
							offset_q[used_q[AW-1:0]] <= start_w;
							shift_q[used_q[AW-1:0]]  <= val_q[2][7:4];
							used_q <= used_q + 5'd1;
							rsp_q.area_count <= 4'(used_q + 5'd1);
							next_q <= 16'(nl_adj + 16'(32'(size9) << val_q[2][7:4]));
						end
					end else if (kind_q == TLV_RESMEM) begin
						for (int i = 0; i < MAX_AREAS; i++) begin
							if (5'(i) < used_q && first_q[i] <= start_w)
								first_q[i] <= first_q[i] + size_w;
						end
						if (start_w <= next_q) next_q <= next_q + size_w;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/nfc_type1_lock_area_tracker_top.sv =====
// ----------------------------------------------------------------------------
// nfc_type1_lock_area_tracker_top
// Tag memory copy, control TLV parser and lock query for Type 1 tags.
// ----------------------------------------------------------------------------
// Every request yields one result. A two-entry request queue feeds the
// execution unit, which handles writes, clears and most TLV bytes in its
// execute state, and passes through a further state for a lock query
// (registered tag memory read) or for the byte that completes a TLV (area
// table update). Results are held in an output register until popped; the
// next request starts in the cycle the held result is popped.
module nfc_type1_lock_area_tracker_top #(
	parameter int MEM_BYTES = 2048,
	parameter int MAX_AREAS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  nfct1_pkg::req_t request,
	output logic            empty,
	input  logic            pop,
	output nfct1_pkg::rsp_t result
);
	import nfct1_pkg::*;

	logic req_valid, req_take;
	req_t req;

	nfct1_front u_front (
		.clk, .arst_n, .push, .full, .request,
		.req_valid, .req, .req_take
	);

	nfct1_back #(.MEM_BYTES(MEM_BYTES), .MAX_AREAS(MAX_AREAS)) u_back (
		.clk, .arst_n, .req_valid, .req, .req_take,
		.empty, .pop, .result
	);

endmodule
